>>> rtl/core/bsdf_pkg.sv
// bsdf_pkg: shared types, constants and helpers for the bond spring/damper force pipeline.
// Used by bond_spring_damper_force, bsdf_checker and tb; depends on nothing else.
`timescale 1ns / 1ps
package bsdf_pkg;

  localparam int FRAC_BITS = 16;

  // Pipeline depth: entry, squares, radicand, 33 root steps, 17 quotient steps,
  // sign, three multiply levels, sum, force multiply, output.
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 17;
  localparam int ST_SQRT0   = 3;
  localparam int ST_DIV0    = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_SIGN    = ST_DIV0 + DIV_STEPS;
  localparam int NSTAGE     = ST_SIGN + 7;

  localparam int IN_W   = 312;
  localparam int OUT_W  = 96;
  localparam int IDX_W  = 3;
  localparam int CDATA_W = 24;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LENGTH_SCALE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_BASE_STIFFNESS = 3'd1;
  localparam logic [IDX_W-1:0] REG_ORDER_GAIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_DAMPING_COEFF  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_DIST_SQ    = 3'd4;

  // Rest length factors per bond order, Q1.16
  localparam logic [16:0] ORD_F1 = 17'd65536;
  localparam logic [16:0] ORD_F2 = 17'd57672;
  localparam logic [16:0] ORD_F3 = 17'd51118;

  localparam logic signed [48:0] FMAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] FMIN = -49'sh0_8000_0000_0000;

  typedef struct packed {
    logic               sx;
    logic               sy;
    logic [32:0]        mx;
    logic [32:0]        my;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic [24:0]        rsum;
    logic [1:0]         ord;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [40:0]        rsl;
    logic [18:0]        factor;
    logic [65:0]        rad;
    logic               skip;
    logic [25:0]        rest;
    logic [26:0]        k;
    logic [35:0]        sq_rem;
    logic [32:0]        sq_root;
    logic [32:0]        rx;
    logic [32:0]        ry;
    logic [16:0]        qx;
    logic [16:0]        qy;
    logic signed [33:0] ext;
    logic signed [17:0] ux;
    logic signed [17:0] uy;
    logic signed [61:0] sprod;
    logic signed [50:0] apx;
    logic signed [50:0] apy;
    logic signed [45:0] spring;
    logic signed [35:0] along;
    logic signed [60:0] dprod;
    logic signed [46:0] total;
    logic signed [64:0] fxp;
    logic signed [64:0] fyp;
    logic [47:0]        fx;
    logic [47:0]        fy;
  } item_t;

  function automatic logic [16:0] order_factor(input logic [1:0] ord);
    logic [16:0] f;
    unique case (ord)
      2'd2:    f = ORD_F2;
      2'd3:    f = ORD_F3;
      default: f = ORD_F1;
    endcase
    return f;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [48:0] v);
    logic [47:0] r;
    if (v > FMAX) begin
      r = FMAX[47:0];
    end else if (v < FMIN) begin
      r = FMIN[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bond_spring_damper_force.sv
// bond_spring_damper_force: top level, pipelined damped spring force on one 2D bond.
// Depends on bsdf_pkg.
`timescale 1ns / 1ps
// Takes one bond request per clock while the output is not stalled (positions,
// velocities, radii, order) and returns the force on atom A, one result per
// request in order; atom B gets the negation. Throughput is one request per
// cycle unless the output stalls: the 33-step square root and the 17-step
// quotient for the unit direction are each unrolled into one register stage
// per step. A stalled output freezes the whole pipe; the input is ready
// whenever the output register is empty or being taken. Pairs whose squared
// distance is below min_dist_sq (Q0.16) or zero come out with skipped set
// and zero force. Forces are Q32.16, clamped to 48 bits. Configuration writes
// take effect at once and belong only in idle periods.
module bond_spring_damper_force (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
  // radius_a, radius_b, bond_order, 6 zero pad bits
  input  logic [bsdf_pkg::IN_W-1:0]       s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // force_x, force_y
  output logic [bsdf_pkg::OUT_W-1:0]      m_tdata,
  // skipped
  output logic [0:0]                      m_tuser,
  input  logic                            cfg_we,
  input  logic [bsdf_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bsdf_pkg::CDATA_W-1:0]    cfg_data
);

  logic [15:0] length_scale;
  logic [23:0] base_stiffness;
  logic [16:0] order_gain;
  logic [23:0] damping_coeff;
  logic [15:0] min_dist_sq;

  bsdf_pkg::item_t pl [bsdf_pkg::NSTAGE];
  bsdf_pkg::item_t nx [bsdf_pkg::NSTAGE];
  logic [bsdf_pkg::NSTAGE-1:0] vld;
  logic adv;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      length_scale   <= 16'd36045;
      base_stiffness <= 24'd3276800;
      order_gain     <= 17'd52429;
      damping_coeff  <= 24'd393216;
      min_dist_sq    <= 16'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsdf_pkg::REG_LENGTH_SCALE:   length_scale   <= cfg_data[15:0];
        bsdf_pkg::REG_BASE_STIFFNESS: base_stiffness <= cfg_data;
        bsdf_pkg::REG_ORDER_GAIN:     order_gain     <= cfg_data[16:0];
        bsdf_pkg::REG_DAMPING_COEFF:  damping_coeff  <= cfg_data;
        bsdf_pkg::REG_MIN_DIST_SQ:    min_dist_sq    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage functions ----------------
  // entry: differences and magnitudes
  function automatic bsdf_pkg::item_t f_entry(input logic [bsdf_pkg::IN_W-1:0] d);
    bsdf_pkg::item_t it;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    it = '0;
    dx = $signed({d[95], d[95:64]}) - $signed({d[31], d[31:0]});
    dy = $signed({d[127], d[127:96]}) - $signed({d[63], d[63:32]});
    it.sx  = dx[32];
    it.sy  = dy[32];
    it.mx  = dx[32] ? 33'(-dx) : 33'(dx);
    it.my  = dy[32] ? 33'(-dy) : 33'(dy);
    it.rvx = $signed({d[223], d[223:192]}) - $signed({d[159], d[159:128]});
    it.rvy = $signed({d[255], d[255:224]}) - $signed({d[191], d[191:160]});
    it.rsum = {1'b0, d[279:256]} + {1'b0, d[303:280]};
    it.ord  = (d[305:304] == 2'd0) ? 2'd1 : d[305:304];
    return it;
  endfunction

  // squares, scaled radius sum, stiffness factor
  function automatic bsdf_pkg::item_t f_s1(input bsdf_pkg::item_t i, input logic [15:0] ls,
                                           input logic [16:0] og);
    bsdf_pkg::item_t it;
    it = i;
    it.sqx = 64'(it.mx) * 64'(it.mx);
    it.sqy = 64'(it.my) * 64'(it.my);
    it.rsl = 41'(it.rsum) * 41'(ls);
    unique case (it.ord)
      2'd2:    it.factor = 19'd65536 + 19'(og);
      2'd3:    it.factor = 19'd65536 + 19'({og, 1'b0});
      default: it.factor = 19'd65536;
    endcase
    return it;
  endfunction

  // radicand, skip test, rest length, stiffness
  function automatic bsdf_pkg::item_t f_s2(input bsdf_pkg::item_t i, input logic [15:0] mds,
                                           input logic [23:0] bs);
    bsdf_pkg::item_t it;
    logic [41:0] rp;
    logic [42:0] kp;
    it = i;
    it.rad  = 66'(it.sqx) + 66'(it.sqy);
    it.skip = (it.rad < 66'({mds, 16'd0})) || (it.rad == 66'd0);
    rp = 42'(it.rsl[40:bsdf_pkg::FRAC_BITS]) * 42'(bsdf_pkg::order_factor(it.ord));
    it.rest = rp[41:bsdf_pkg::FRAC_BITS];
    kp = 43'(bs) * 43'(it.factor);
    it.k = kp[42:bsdf_pkg::FRAC_BITS];
    it.sq_rem  = '0;
    it.sq_root = '0;
    return it;
  endfunction

  // one restoring square root step on radicand bit pair pos
  function automatic bsdf_pkg::item_t f_sqrt(input bsdf_pkg::item_t i, input int pos);
    bsdf_pkg::item_t it;
    logic [35:0] r;
    logic [35:0] trial;
    it = i;
    r = {it.sq_rem[33:0], it.rad[2*pos +: 2]};
    trial = {1'b0, it.sq_root, 2'b01};
    if (r >= trial) begin
      it.sq_rem  = r - trial;
      it.sq_root = {it.sq_root[31:0], 1'b1};
    end else begin
      it.sq_rem  = r;
      it.sq_root = {it.sq_root[31:0], 1'b0};
    end
    return it;
  endfunction

  // one quotient bit of |d| << 16 / dist for both axes
  function automatic bsdf_pkg::item_t f_div(input bsdf_pkg::item_t i, input logic first);
    bsdf_pkg::item_t it;
    logic [33:0] tx;
    logic [33:0] ty;
    logic [33:0] dd;
    logic [16:0] qx;
    logic [16:0] qy;
    it = i;
    dd = {1'b0, it.sq_root};
    if (first) begin
      tx = {1'b0, it.mx[32:1], it.mx[0]};
      ty = {1'b0, it.my[32:1], it.my[0]};
      qx = '0;
      qy = '0;
      it.ext = $signed({1'b0, it.sq_root}) - $signed({8'd0, it.rest});
    end else begin
      tx = {it.rx, 1'b0};
      ty = {it.ry, 1'b0};
      qx = it.qx;
      qy = it.qy;
    end
    if (tx >= dd) begin
      tx = tx - dd;
      it.qx = {qx[15:0], 1'b1};
    end else begin
      it.qx = {qx[15:0], 1'b0};
    end
    if (ty >= dd) begin
      ty = ty - dd;
      it.qy = {qy[15:0], 1'b1};
    end else begin
      it.qy = {qy[15:0], 1'b0};
    end
    it.rx = tx[32:0];
    it.ry = ty[32:0];
    return it;
  endfunction

  function automatic bsdf_pkg::item_t f_sign(input bsdf_pkg::item_t i);
    bsdf_pkg::item_t it;
    logic signed [17:0] qx;
    logic signed [17:0] qy;
    it = i;
    qx = $signed({1'b0, it.qx});
    qy = $signed({1'b0, it.qy});
    it.ux = it.sx ? -qx : qx;
    it.uy = it.sy ? -qy : qy;
    return it;
  endfunction

  function automatic bsdf_pkg::item_t f_mul1(input bsdf_pkg::item_t i);
    bsdf_pkg::item_t it;
    logic signed [61:0] ka;
    logic signed [61:0] ea;
    logic signed [50:0] va;
    logic signed [50:0] ua;
    logic signed [50:0] vb;
    logic signed [50:0] ub;
    it = i;
    ka = $signed({35'd0, it.k});
    ea = it.ext;
    it.sprod = ka * ea;
    va = it.rvx;
    ua = it.ux;
    vb = it.rvy;
    ub = it.uy;
    it.apx = va * ua;
    it.apy = vb * ub;
    return it;
  endfunction

  function automatic bsdf_pkg::item_t f_s2b(input bsdf_pkg::item_t i);
    bsdf_pkg::item_t it;
    logic signed [51:0] a;
    logic signed [51:0] b;
    logic signed [51:0] s;
    it = i;
    it.spring = it.sprod[61:bsdf_pkg::FRAC_BITS];
    a = it.apx;
    b = it.apy;
    s = a + b;
    it.along = s[51:bsdf_pkg::FRAC_BITS];
    return it;
  endfunction

  function automatic bsdf_pkg::item_t f_damp(input bsdf_pkg::item_t i, input logic [23:0] dc);
    bsdf_pkg::item_t it;
    logic signed [60:0] ca;
    logic signed [60:0] la;
    it = i;
    ca = $signed({37'd0, dc});
    la = it.along;
    it.dprod = ca * la;
    return it;
  endfunction

  function automatic bsdf_pkg::item_t f_total(input bsdf_pkg::item_t i);
    bsdf_pkg::item_t it;
    logic signed [46:0] sa;
    logic signed [46:0] da;
    it = i;
    sa = it.spring;
    // damping term is signed, keep its sign when widening
    da = $signed(it.dprod[60:bsdf_pkg::FRAC_BITS]);
    it.total = sa + da;
    return it;
  endfunction

  function automatic bsdf_pkg::item_t f_fmul(input bsdf_pkg::item_t i);
    bsdf_pkg::item_t it;
    logic signed [64:0] ta;
    logic signed [64:0] xa;
    logic signed [64:0] ya;
    it = i;
    ta = it.total;
    xa = it.ux;
    ya = it.uy;
    it.fxp = ta * xa;
    it.fyp = ta * ya;
    return it;
  endfunction

  function automatic bsdf_pkg::item_t f_out(input bsdf_pkg::item_t i);
    bsdf_pkg::item_t it;
    it = i;
    if (it.skip) begin
      it.fx = '0;
      it.fy = '0;
    end else begin
      it.fx = bsdf_pkg::sat48(it.fxp[64:bsdf_pkg::FRAC_BITS]);
      it.fy = bsdf_pkg::sat48(it.fyp[64:bsdf_pkg::FRAC_BITS]);
    end
    return it;
  endfunction

  // ---------------- stage wiring ----------------
  assign nx[0] = f_entry(s_tdata);
  assign nx[1] = f_s1(pl[0], length_scale, order_gain);
  assign nx[2] = f_s2(pl[1], min_dist_sq, base_stiffness);

  for (genvar g = 0; g < bsdf_pkg::SQRT_STEPS; g++) begin : g_sqrt
    assign nx[bsdf_pkg::ST_SQRT0+g] = f_sqrt(pl[bsdf_pkg::ST_SQRT0+g-1],
                                             bsdf_pkg::SQRT_STEPS - 1 - g);
  end

  for (genvar g = 0; g < bsdf_pkg::DIV_STEPS; g++) begin : g_div
    assign nx[bsdf_pkg::ST_DIV0+g] = f_div(pl[bsdf_pkg::ST_DIV0+g-1], (g == 0));
  end

  assign nx[bsdf_pkg::ST_SIGN]   = f_sign(pl[bsdf_pkg::ST_SIGN-1]);
  assign nx[bsdf_pkg::ST_SIGN+1] = f_mul1(pl[bsdf_pkg::ST_SIGN]);
  assign nx[bsdf_pkg::ST_SIGN+2] = f_s2b(pl[bsdf_pkg::ST_SIGN+1]);
  assign nx[bsdf_pkg::ST_SIGN+3] = f_damp(pl[bsdf_pkg::ST_SIGN+2], damping_coeff);
  assign nx[bsdf_pkg::ST_SIGN+4] = f_total(pl[bsdf_pkg::ST_SIGN+3]);
  assign nx[bsdf_pkg::ST_SIGN+5] = f_fmul(pl[bsdf_pkg::ST_SIGN+4]);
  assign nx[bsdf_pkg::ST_SIGN+6] = f_out(pl[bsdf_pkg::ST_SIGN+5]);

  // whole pipe moves when the output register is free or being drained
  assign adv      = !vld[bsdf_pkg::NSTAGE-1] || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[bsdf_pkg::NSTAGE-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < bsdf_pkg::NSTAGE; j++) begin
        pl[j] <= nx[j];
      end
    end
  end

  assign m_tvalid   = vld[bsdf_pkg::NSTAGE-1];
  assign m_tdata    = {pl[bsdf_pkg::NSTAGE-1].fy, pl[bsdf_pkg::NSTAGE-1].fx};
  assign m_tuser[0] = pl[bsdf_pkg::NSTAGE-1].skip;

endmodule

>>> rtl/core/bsdf_checker.sv
// bsdf_checker: port-level checks for bond_spring_damper_force, bound to the top level.
// Depends on bsdf_pkg.
`timescale 1ns / 1ps
module bsdf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [bsdf_pkg::IN_W-1:0]     s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bsdf_pkg::OUT_W-1:0]    m_tdata,
  input logic [0:0]                    m_tuser,
  input logic                          cfg_we,
  input logic [bsdf_pkg::IDX_W-1:0]    cfg_index,
  input logic [bsdf_pkg::CDATA_W-1:0]  cfg_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // skipped pairs carry zero force
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("skipped request with nonzero force");

  // empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a stalled output freezes the pipe
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind bond_spring_damper_force bsdf_checker u_bsdf_checker (.*);

>>> tb/tb.sv
// tb: self-checking bench for bond_spring_damper_force; predicts each force request
// in order and compares forces and skip flag. Depends on bsdf_pkg and the RTL top.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [47:0] fx;
    logic [47:0] fy;
    logic        skip;
  } force_t;

  typedef struct {
    logic [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
    logic [23:0] ra, rb;
    logic [1:0]  ord;
  } bond_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [bsdf_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [bsdf_pkg::OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_we = 0;
  logic [bsdf_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bsdf_pkg::CDATA_W-1:0] cfg_data = '0;

  // shadow copy of the register file
  logic [15:0] sh_scale;
  logic [23:0] sh_stiff;
  logic [16:0] sh_gain;
  logic [23:0] sh_damp;
  logic [15:0] sh_mind;

  force_t pending_forces[$];
  int  errors = 0;
  int  stall_cycles = 0;
  bit  calm = 0;        // no idling on either side
  int  s_idle = 0;

  bond_spring_damper_force u_dut (.*);

  always #2 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [33:0] root66(input logic [65:0] v);
    logic [67:0] rem;
    logic [33:0] rt;
    logic [67:0] trial;
    rem = '0;
    rt = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = {rt, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        rt = {rt[32:0], 1'b1};
      end else begin
        rt = {rt[32:0], 1'b0};
      end
    end
    return rt;
  endfunction

  function automatic logic signed [127:0] unit_of(input logic signed [127:0] d,
                                                  input logic [33:0] dlen);
    logic [127:0] mag, q;
    mag = d < 0 ? -d : d;
    q = (mag << bsdf_pkg::FRAC_BITS) / dlen;
    return d < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [47:0] clamp48(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
    if (v < -128'sh8000_0000_0000) return 48'h8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic force_t bond_force(input bond_t b);
    logic signed [127:0] dx, dy, ux, uy, ext, spring, rvx, rvy, along, damp, total;
    logic [127:0] sq, rest, factor, k, ofac;
    logic [33:0] dlen;
    logic [1:0] ord;
    force_t f;
    dx = $signed(b.pbx) - $signed(b.pax);
    dy = $signed(b.pby) - $signed(b.pay);
    sq = dx * dx + dy * dy;
    f = '0;
    if (sq < ({112'd0, sh_mind} << bsdf_pkg::FRAC_BITS)) begin
      f.skip = 1'b1;
      return f;
    end
    dlen = root66(sq[65:0]);
    if (dlen == 0) begin
      f.skip = 1'b1;
      return f;
    end
    ord = (b.ord == 2'd0) ? 2'd1 : b.ord;
    ofac = ord == 2'd1 ? 128'd65536 : ord == 2'd2 ? 128'd57672 : 128'd51118;
    ux = unit_of(dx, dlen);
    uy = unit_of(dy, dlen);
    rest = ((((b.ra + 128'd0) + b.rb) * sh_scale) >> 16) * ofac >> 16;
    factor = 128'd65536 + sh_gain * (ord - 128'd1);
    k = (sh_stiff * factor) >> 16;
    ext = $signed({94'd0, dlen}) - $signed(rest);
    spring = ($signed(k) * ext) >>> bsdf_pkg::FRAC_BITS;
    rvx = $signed(b.vbx) - $signed(b.vax);
    rvy = $signed(b.vby) - $signed(b.vay);
    along = (rvx * ux + rvy * uy) >>> bsdf_pkg::FRAC_BITS;
    damp = ($signed({104'd0, sh_damp}) * along) >>> bsdf_pkg::FRAC_BITS;
    total = spring + damp;
    f.fx = clamp48((total * ux) >>> bsdf_pkg::FRAC_BITS);
    f.fy = clamp48((total * uy) >>> bsdf_pkg::FRAC_BITS);
    return f;
  endfunction

  // ---------------- drivers ----------------
  task automatic write_reg(input logic [bsdf_pkg::IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      bsdf_pkg::REG_LENGTH_SCALE:   sh_scale = val[15:0];
      bsdf_pkg::REG_BASE_STIFFNESS: sh_stiff = val;
      bsdf_pkg::REG_ORDER_GAIN:     sh_gain = val[16:0];
      bsdf_pkg::REG_DAMPING_COEFF:  sh_damp = val;
      bsdf_pkg::REG_MIN_DIST_SQ:    sh_mind = val[15:0];
      default: ;
    endcase
  endtask

  // send one bond request; valid stays high across back-to-back requests
  task automatic send_bond(input bond_t b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tdata <= {6'd0, b.ord, b.rb, b.ra, b.vby, b.vbx, b.vay, b.vax,
                b.pby, b.pbx, b.pay, b.pax};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    pending_forces.push_back(bond_force(b));
  endtask

  task automatic idle_input();
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  // wait until every expected force is back, then let the pipe settle
  task automatic drain();
    idle_input();
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // output-side stalls in random bursts
  always @(negedge clk) begin
    if (calm) begin
      m_tready <= 1;
    end else if (s_idle > 0) begin
      s_idle <= s_idle - 1;
      m_tready <= 0;
    end else if ($urandom_range(0, 4) == 0) begin
      s_idle <= $urandom_range(0, 3);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_forces.size() == 0) begin
        $display("%0t unexpected result fx=%h fy=%h skip=%b", $time,
                 m_tdata[47:0], m_tdata[95:48], m_tuser[0]);
        errors++;
      end else begin
        force_t e;
        e = pending_forces.pop_front();
        if (m_tdata[47:0] !== e.fx) begin
          $display("%0t force_x exp %h got %h", $time, e.fx, m_tdata[47:0]);
          errors++;
        end
        if (m_tdata[95:48] !== e.fy) begin
          $display("%0t force_y exp %h got %h", $time, e.fy, m_tdata[95:48]);
          errors++;
        end
        if (m_tuser[0] !== e.skip) begin
          $display("%0t skipped exp %b got %b", $time, e.skip, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 3000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic bond_t rand_bond(input int mode);
    bond_t b;
    logic [31:0] sp;
    b.pax = $urandom; b.pay = $urandom;
    b.vax = $urandom; b.vay = $urandom; b.vbx = $urandom; b.vby = $urandom;
    b.ra = 24'($urandom); b.rb = 24'($urandom);
    b.ord = 2'($urandom_range(0, 3));
    case (mode)
      0: begin // full random, saturates often
        b.pbx = $urandom; b.pby = $urandom;
      end
      1: begin // physical bond: distance near a few units
        sp = $urandom_range(0, 32'h0004_0000);
        b.pbx = b.pax + sp - 32'h0002_0000;
        b.pby = b.pay + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        b.ra = 24'($urandom_range(0, 32'h0002_0000));
        b.rb = 24'($urandom_range(0, 32'h0002_0000));
        b.vax = $signed($urandom) >>> $urandom_range(8, 24);
        b.vbx = $signed($urandom) >>> $urandom_range(8, 24);
      end
      default: begin // near coincidence
        b.pbx = b.pax + $urandom_range(0, 1200) - 600;
        b.pby = b.pay + $urandom_range(0, 1200) - 600;
      end
    endcase
    return b;
  endfunction

  task automatic test_reset_defaults();
    sh_scale = 16'd36045; sh_stiff = 24'd3276800; sh_gain = 17'd52429;
    sh_damp = 24'd393216; sh_mind = 16'd7;
    for (int i = 0; i < 8; i++) send_bond(rand_bond(i % 3));
    drain();
  endtask

  task automatic test_directed();
    bond_t b;
    b = rand_bond(1);
    // identical atoms: zero distance
    b.pbx = b.pax; b.pby = b.pay; send_bond(b);
    // just below and just above the skip threshold
    b = rand_bond(1); b.pbx = b.pax + 32'd676; b.pby = b.pay; send_bond(b);
    b.pbx = b.pax + 32'd678; send_bond(b);
    // every order including zero
    for (int o = 0; o < 4; o++) begin
      b = rand_bond(1); b.ord = 2'(o); send_bond(b);
    end
    // position and velocity extremes
    b.pax = 32'h8000_0000; b.pay = 32'h8000_0000;
    b.pbx = 32'h7FFF_FFFF; b.pby = 32'h7FFF_FFFF;
    b.vax = 32'h8000_0000; b.vay = 32'h8000_0000;
    b.vbx = 32'h7FFF_FFFF; b.vby = 32'h7FFF_FFFF;
    b.ra = 24'hFF_FFFF; b.rb = 24'hFF_FFFF; b.ord = 2'd3; send_bond(b);
    b.pax = 32'h7FFF_FFFF; b.pbx = 32'h8000_0000; b.pay = 32'd0; b.pby = 32'd0;
    b.ra = 24'd0; b.rb = 24'd0; b.ord = 2'd1; send_bond(b);
    b.pay = 32'h7FFF_FFFF; b.pby = 32'h8000_0000; b.pax = 32'd0; b.pbx = 32'd0;
    b.vax = 32'h7FFF_FFFF; b.vbx = 32'h8000_0000; send_bond(b);
    drain();
  endtask

  task automatic test_config_extremes();
    // all zero: no spring, no damping, zero threshold
    write_reg(bsdf_pkg::REG_LENGTH_SCALE, 24'd0);
    write_reg(bsdf_pkg::REG_BASE_STIFFNESS, 24'd0);
    write_reg(bsdf_pkg::REG_ORDER_GAIN, 24'd0);
    write_reg(bsdf_pkg::REG_DAMPING_COEFF, 24'd0);
    write_reg(bsdf_pkg::REG_MIN_DIST_SQ, 24'd0);
    for (int i = 0; i < 12; i++) send_bond(rand_bond(i % 3));
    drain();
    // all at maximum
    write_reg(bsdf_pkg::REG_LENGTH_SCALE, 24'h00_FFFF);
    write_reg(bsdf_pkg::REG_BASE_STIFFNESS, 24'hFF_FFFF);
    write_reg(bsdf_pkg::REG_ORDER_GAIN, 24'h01_FFFF);
    write_reg(bsdf_pkg::REG_DAMPING_COEFF, 24'hFF_FFFF);
    write_reg(bsdf_pkg::REG_MIN_DIST_SQ, 24'h00_FFFF);
    for (int i = 0; i < 12; i++) send_bond(rand_bond(i % 3));
    drain();
  endtask

  task automatic test_random(input int n, input bit no_idle);
    calm = no_idle;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        drain();
        write_reg(bsdf_pkg::REG_LENGTH_SCALE, 24'($urandom_range(0, 16'hFFFF)));
        write_reg(bsdf_pkg::REG_BASE_STIFFNESS, 24'($urandom_range(0, 24'hFF_FFFF)));
        write_reg(bsdf_pkg::REG_ORDER_GAIN, 24'($urandom_range(0, 17'h1_FFFF)));
        write_reg(bsdf_pkg::REG_DAMPING_COEFF, 24'($urandom_range(0, 24'hFF_FFFF)));
        write_reg(bsdf_pkg::REG_MIN_DIST_SQ, 24'($urandom_range(0, 40)));
      end
      send_bond(rand_bond($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 2)));
      // hold off until the pipe is empty once in a while
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_reset_defaults();
    test_directed();
    test_config_extremes();
    test_random(1000, 0);
    test_random(250, 1);
    if (errors == 0 && pending_forces.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
